### src/tprms_pkg.sv
// Shared types, widths and constants of the three-phase RMS averager.
package tprms_pkg;

  localparam int AVG_SAMPLES = 16;
  localparam int AVG_SHIFT   = 4;

  localparam int NUM_PHASES = 3;
  localparam int PH_W       = 2;
  localparam int FLAG_W     = 3;
  localparam int VAL_W      = 24;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 5;
  localparam int RES_W      = 16;
  localparam int PWR_W      = 24;
  localparam int OFF_W      = 11;
  localparam int GAIN_W     = OFF_W + 1;
  localparam int CT_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PH_W-1:0] PH_LAST = PH_W'(NUM_PHASES - 1);

  // Voltage readings are accumulated times eight.
  localparam int VOLT_SCALE_SHIFT = 3;

  // Low-current thresholds chosen from the CT ratio.
  localparam logic [CT_W-1:0]  CT_LIM_LOW  = CT_W'(61);
  localparam logic [CT_W-1:0]  CT_LIM_MID  = CT_W'(201);
  localparam logic [RES_W-1:0] THR_LOW     = RES_W'(8);
  localparam logic [RES_W-1:0] THR_MID     = RES_W'(40);
  localparam logic [RES_W-1:0] THR_HIGH    = RES_W'(80);

  // Per-mille gain and the reciprocal constants of the divide by 1000.
  localparam int GAIN_UNITY      = 1000;
  localparam int DIV_PRE_SHIFT   = 3;
  localparam int Q_IN_W          = SUM_W - DIV_PRE_SHIFT;
  localparam int RECIP1_W        = 30;
  localparam int RECIP1_SHIFT    = 36;
  localparam logic [RECIP1_W-1:0] RECIP1 = 30'd549755814;
  localparam int Q_W             = 23;
  localparam int REM_W           = 10;
  localparam int LO_W            = 21;
  localparam int RECIP2_W        = 22;
  localparam int RECIP2_SHIFT    = 31;
  localparam logic [RECIP2_W-1:0] RECIP2 = 22'd2147484;

  // Register stages of the gain scaler.
  localparam int SCALE_LAT = 5;

  // Result queue depth; also the bound on items in flight.
  localparam int FIFO_DEPTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_MODE   = 3'd0,
    REG_CT_RATIO    = 3'd1,
    REG_VOLT_OFF_A  = 3'd2,
    REG_VOLT_OFF_B  = 3'd3,
    REG_VOLT_OFF_C  = 3'd4,
    REG_CURR_OFF_A  = 3'd5,
    REG_CURR_OFF_B  = 3'd6,
    REG_CURR_OFF_C  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PH_W-1:0]          phase;
    logic [FLAG_W-1:0]        absent_flags;
    logic [VAL_W-1:0]         voltage_reading;
    logic [VAL_W-1:0]         current_reading;
    logic signed [VAL_W-1:0]  energy_reading;
  } in_item_t;

  typedef struct packed {
    logic [PH_W-1:0]          out_phase;
    logic                     block_done;
    logic [RES_W-1:0]         voltage_avg;
    logic [RES_W-1:0]         current_avg;
    logic signed [PWR_W-1:0]  power_avg;
    logic                     low_current;
  } out_item_t;

  // Per-item control traveling alongside the scaler pipeline.
  typedef struct packed {
    logic                     valid;
    logic [PH_W-1:0]          ph;
    logic                     done;
    logic signed [PWR_W-1:0]  power;
  } blk_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] vsum;
    logic [SUM_W-1:0] csum;
    logic [SUM_W-1:0] esum;
    logic [CNT_W-1:0] cnt;
  } sums_t;

  typedef struct packed {
    logic [RES_W-1:0]         vres;
    logic [RES_W-1:0]         cres;
    logic signed [PWR_W-1:0]  pres;
  } res_t;

endpackage

### src/tprms_scale.sv
// Pipelined per-mille gain scaler: result = low 16 bits of base * (1000 + offset) / 1000.
module tprms_scale
  import tprms_pkg::*;
(
  input  logic                    clk,
  input  logic [SUM_W-1:0]        base,
  input  logic signed [OFF_W-1:0] offset,
  output logic [RES_W-1:0]        result
);

  localparam int P1_W = Q_IN_W + RECIP1_W;
  localparam int HI_W = RES_W + OFF_W;
  localparam int TP_W = LO_W + RECIP2_W;

  logic signed [GAIN_W-1:0] gain;
  logic                     neg0;
  logic [OFF_W-1:0]         mag0;
  logic [P1_W-1:0]          p1;

  logic [Q_W-1:0]           q1;
  logic [SUM_W-1:0]         base1;
  logic [OFF_W-1:0]         mag1;
  logic                     neg1;
  logic [SUM_W-1:0]         diff;

  logic [REM_W-1:0]         rem2;
  logic [RES_W-1:0]         q16_2;
  logic [OFF_W-1:0]         mag2;
  logic                     neg2;
  logic [HI_W-1:0]          hi_prod;
  logic [LO_W-1:0]          lo_prod;

  logic [RES_W-1:0]         hi3;
  logic [LO_W-1:0]          lo3;
  logic                     neg3;
  logic [TP_W-1:0]          t_prod;

  logic [RES_W-1:0]         hi4;
  logic [OFF_W-1:0]         t4;
  logic                     neg4;
  logic [RES_W-1:0]         sum4;

  // Truncation toward zero: scale the magnitude, then restore the sign.
  assign gain = GAIN_W'(offset) + GAIN_W'(GAIN_UNITY);
  assign neg0 = gain[GAIN_W-1];
  assign mag0 = neg0 ? OFF_W'(-gain) : OFF_W'(gain);

  // base / 1000 = (base / 8) / 125, exact by reciprocal for a 29-bit dividend.
  assign p1 = P1_W'(base[SUM_W-1:DIV_PRE_SHIFT]) * P1_W'(RECIP1);

  assign diff    = base1 - SUM_W'(q1) * SUM_W'(GAIN_UNITY);
  assign hi_prod = HI_W'(q16_2) * HI_W'(mag2);
  assign lo_prod = LO_W'(rem2) * LO_W'(mag2);
  assign t_prod  = TP_W'(lo3) * TP_W'(RECIP2);
  assign sum4    = hi4 + RES_W'(t4);

  always_ff @(posedge clk) begin
    q1     <= p1[RECIP1_SHIFT +: Q_W];
    base1  <= base;
    mag1   <= mag0;
    neg1   <= neg0;

    rem2   <= diff[REM_W-1:0];
    q16_2  <= q1[RES_W-1:0];
    mag2   <= mag1;
    neg2   <= neg1;

    hi3    <= hi_prod[RES_W-1:0];
    lo3    <= lo_prod;
    neg3   <= neg2;

    t4     <= t_prod[RECIP2_SHIFT +: OFF_W];
    hi4    <= hi3;
    neg4   <= neg3;

    result <= neg4 ? (~sum4 + RES_W'(1)) : sum4;
  end

endmodule

### src/tprms_accum.sv
// Running-sum memory with read-modify-write and block-end detection.
module tprms_accum
  import tprms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  in_item_t         item,
  input  logic             full_mode,
  output blk_ctl_t         ctl,
  output logic [SUM_W-1:0] base_v,
  output logic [SUM_W-1:0] base_c
);

  sums_t                   sums_mem [NUM_PHASES];
  logic [NUM_PHASES-1:0]   ent_valid;
  logic [PH_W-1:0]         rd_addr;
  sums_t                   rd_data;
  logic                    rd_ok;

  logic                    s1_valid;
  logic [PH_W-1:0]         s1_ph;
  logic [VAL_W-1:0]        s1_v;
  logic [VAL_W-1:0]        s1_c;
  logic signed [VAL_W-1:0] s1_e;

  logic                    fwd_valid;
  logic [PH_W-1:0]         fwd_ph;
  sums_t                   fwd_data;

  sums_t                   cur;
  sums_t                   upd;
  sums_t                   wr_data;
  logic                    done;
  logic signed [SUM_W-1:0] e_shift;
  logic                    absent_self;

  logic                    ctl_valid;
  logic [PH_W-1:0]         ctl_ph;
  logic                    ctl_done;
  logic signed [PWR_W-1:0] ctl_power;

  assign rd_addr     = (item.phase > PH_LAST) ? '0 : item.phase;
  assign absent_self = |(item.absent_flags & (FLAG_W'(1) << item.phase));

  // The entry written at the last edge is not yet visible on the read port.
  always_comb begin
    if (fwd_valid && (fwd_ph == s1_ph)) begin
      cur = fwd_data;
    end else if (rd_ok) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    upd.vsum = cur.vsum + (SUM_W'(s1_v) << VOLT_SCALE_SHIFT);
    upd.csum = full_mode ? cur.csum + SUM_W'(s1_c) : cur.csum;
    upd.esum = full_mode ? cur.esum + SUM_W'(s1_e) : cur.esum;
    upd.cnt  = cur.cnt + CNT_W'(1);
    done     = (upd.cnt == CNT_W'(AVG_SAMPLES));
    wr_data  = done ? '0 : upd;
    e_shift  = $signed(upd.esum) >>> AVG_SHIFT;
  end

  assign ctl = '{valid: ctl_valid, ph: ctl_ph, done: ctl_done, power: ctl_power};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      ctl_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      s1_valid  <= take;
      fwd_valid <= s1_valid;
      ctl_valid <= s1_valid;
      if (s1_valid) begin
        ent_valid[s1_ph] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= sums_mem[rd_addr];
    rd_ok   <= ent_valid[rd_addr];
    if (s1_valid) begin
      sums_mem[s1_ph] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    s1_ph     <= item.phase;
    s1_v      <= absent_self ? '0 : item.voltage_reading;
    s1_c      <= absent_self ? '0 : item.current_reading;
    s1_e      <= item.energy_reading;
    fwd_ph    <= s1_ph;
    fwd_data  <= wr_data;
    ctl_ph    <= s1_ph;
    ctl_done  <= done;
    ctl_power <= full_mode ? e_shift[PWR_W-1:0] : '0;
    base_v    <= upd.vsum >> AVG_SHIFT;
    base_c    <= full_mode ? (upd.csum >> AVG_SHIFT) : '0;
  end

endmodule

### src/tprms_result.sv
// Averaged-result memory, low-current check and result assembly.
module tprms_result
  import tprms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [PH_W-1:0]  rd_ph,
  input  blk_ctl_t         ctl,
  input  logic [RES_W-1:0] scale_v,
  input  logic [RES_W-1:0] scale_c,
  input  logic [CT_W-1:0]  ct_ratio,
  output logic             push,
  output out_item_t        item
);

  res_t                  res_mem [NUM_PHASES];
  logic [NUM_PHASES-1:0] ent_valid;
  logic [PH_W-1:0]       rd_addr;
  res_t                  rd_data;
  logic                  rd_ok;

  logic                  fwd_valid;
  logic [PH_W-1:0]       fwd_ph;
  res_t                  fwd_data;

  res_t                  cur;
  res_t                  upd;
  logic [RES_W-1:0]      thr;
  logic                  wr_en;

  assign rd_addr = (rd_ph > PH_LAST) ? '0 : rd_ph;
  assign wr_en   = ctl.valid && ctl.done;
  assign push    = ctl.valid;

  always_comb begin
    if (fwd_valid && (fwd_ph == ctl.ph)) begin
      cur = fwd_data;
    end else if (rd_ok) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    if (ct_ratio < CT_LIM_LOW) begin
      thr = THR_LOW;
    end else if (ct_ratio < CT_LIM_MID) begin
      thr = THR_MID;
    end else begin
      thr = THR_HIGH;
    end
    upd = ctl.done ? res_t'{vres: scale_v, cres: scale_c, pres: ctl.power} : cur;
  end

  // The low-current flag looks at the current average from before this item.
  assign item = '{out_phase:   ctl.ph,
                  block_done:  ctl.done,
                  voltage_avg: upd.vres,
                  current_avg: upd.cres,
                  power_avg:   upd.pres,
                  low_current: (cur.cres < thr)};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      fwd_valid <= wr_en;
      if (wr_en) begin
        ent_valid[ctl.ph] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= res_mem[rd_addr];
    rd_ok   <= ent_valid[rd_addr];
    if (wr_en) begin
      res_mem[ctl.ph] <= upd;
    end
    fwd_ph   <= ctl.ph;
    fwd_data <= upd;
  end

endmodule

### src/three_phase_rms_averager.sv
// Top level of the three-phase RMS averager: configuration, pipeline and result queue.
//
// Usage: each input transaction carries one metering reading for one phase. A reading
// whose phase code is three, or whose three absent flags are all set, is taken and
// dropped without a result. Every other reading produces exactly one output
// transaction, in order, holding the phase's stored averages after this reading.
// Throughput is one reading per clock cycle while in_stall is low. A result can
// first be taken after the running-sum memory read, the read-modify-write of that
// memory, the register stages of the gain scaler (reciprocal divide by 1000) and
// the result memory update. Results wait in a 16-entry queue, so the input keeps
// flowing while the receiver stalls; outside reset, in_stall rises only when
// sixteen results are either queued or in flight.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register per edge,
// and must only change while no reading is in flight.
// Synchronous reset clears the sums, counts and averages of all phases to zero, empties
// the queue and loads full_mode = 1, ct_ratio = 200 and all gain offsets = 0.
// While rst is high, in_stall is held high so no reading is taken.
module three_phase_rms_averager
  import tprms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  // Configuration registers.
  logic                    full_mode;
  logic [CT_W-1:0]         ct_ratio;
  logic signed [OFF_W-1:0] volt_off [NUM_PHASES];
  logic signed [OFF_W-1:0] curr_off [NUM_PHASES];

  logic                    in_take;
  logic                    kept;
  logic                    in_acc;

  blk_ctl_t                acc_ctl;
  logic [SUM_W-1:0]        base_v;
  logic [SUM_W-1:0]        base_c;
  logic signed [OFF_W-1:0] sel_voff;
  logic signed [OFF_W-1:0] sel_coff;
  logic [RES_W-1:0]        scale_v;
  logic [RES_W-1:0]        scale_c;

  // Control delay line that keeps each item aligned with the scaler output.
  blk_ctl_t                dly_ctl   [SCALE_LAT];
  logic [SCALE_LAT-1:0]    dly_valid;
  blk_ctl_t                aligned_ctl;

  logic                    res_push;
  out_item_t               res_item;

  // Result queue.
  out_item_t               fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [OCC_W-1:0]        fifo_cnt;
  logic [OCC_W-1:0]        occ;
  logic                    pop;

  // A reading is accepted whenever credit remains; only kept readings use a credit.
  assign in_stall = rst || (occ >= OCC_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign kept     = (in_data.phase <= PH_LAST) && !(&in_data.absent_flags);
  assign in_take  = in_acc && kept;

  assign out_valid = (fifo_cnt != '0);
  assign out_data  = fifo_mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mode <= 1'b1;
      ct_ratio  <= CT_W'(200);
      for (int i = 0; i < NUM_PHASES; i++) begin
        volt_off[i] <= '0;
        curr_off[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FULL_MODE:  full_mode   <= cfg_data[0];
        REG_CT_RATIO:   ct_ratio    <= cfg_data[CT_W-1:0];
        REG_VOLT_OFF_A: volt_off[0] <= cfg_data[OFF_W-1:0];
        REG_VOLT_OFF_B: volt_off[1] <= cfg_data[OFF_W-1:0];
        REG_VOLT_OFF_C: volt_off[2] <= cfg_data[OFF_W-1:0];
        REG_CURR_OFF_A: curr_off[0] <= cfg_data[OFF_W-1:0];
        REG_CURR_OFF_B: curr_off[1] <= cfg_data[OFF_W-1:0];
        REG_CURR_OFF_C: curr_off[2] <= cfg_data[OFF_W-1:0];
      endcase
    end
  end

  tprms_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (in_take),
    .item      (in_data),
    .full_mode (full_mode),
    .ctl       (acc_ctl),
    .base_v    (base_v),
    .base_c    (base_c)
  );

  // The scalers take the gain offsets of the phase that enters them this cycle.
  always_comb begin
    case (acc_ctl.ph)
      2'd1: begin
        sel_voff = volt_off[1];
        sel_coff = curr_off[1];
      end
      2'd2: begin
        sel_voff = volt_off[2];
        sel_coff = curr_off[2];
      end
      default: begin
        sel_voff = volt_off[0];
        sel_coff = curr_off[0];
      end
    endcase
  end

  tprms_scale u_scale_v (
    .clk    (clk),
    .base   (base_v),
    .offset (sel_voff),
    .result (scale_v)
  );

  tprms_scale u_scale_c (
    .clk    (clk),
    .base   (base_c),
    .offset (sel_coff),
    .result (scale_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_valid <= '0;
    end else begin
      dly_valid <= {dly_valid[SCALE_LAT-2:0], acc_ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    dly_ctl[0] <= acc_ctl;
    for (int k = 1; k < SCALE_LAT; k++) begin
      dly_ctl[k] <= dly_ctl[k-1];
    end
  end

  assign aligned_ctl = '{valid: dly_valid[SCALE_LAT-1],
                         ph:    dly_ctl[SCALE_LAT-1].ph,
                         done:  dly_ctl[SCALE_LAT-1].done,
                         power: dly_ctl[SCALE_LAT-1].power};

  // The result memory is read one stage ahead so its data meets the scaler output.
  tprms_result u_result (
    .clk      (clk),
    .rst      (rst),
    .rd_ph    (dly_ctl[SCALE_LAT-2].ph),
    .ctl      (aligned_ctl),
    .scale_v  (scale_v),
    .scale_c  (scale_c),
    .ct_ratio (ct_ratio),
    .push     (res_push),
    .item     (res_item)
  );

  // Credit counter: kept readings in flight plus results still queued.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      fifo_cnt <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      occ      <= occ + OCC_W'(in_take) - OCC_W'(pop);
      fifo_cnt <= fifo_cnt + OCC_W'(res_push) - OCC_W'(pop);
      if (res_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      fifo_mem[wr_ptr] <= res_item;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("credit counter exceeds queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= occ)
    else $error("more queued results than credited readings");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (fifo_cnt < OCC_W'(FIFO_DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc_ctl.valid |-> ##SCALE_LAT res_push)
    else $error("accumulated item did not reach the result stage");

endmodule
